@@ rtl/ndpa_pkg.sv @@
package ndpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SLOPE_W   = 8;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = DATA_W + 1;
  localparam int SIG_W     = (FRAC_BITS + 6 > MAG_W) ? FRAC_BITS + 6 : MAG_W;

  // activation codes; anything else passes through
  localparam logic [MODE_W-1:0] ACT_NONE    = MODE_W'(0);
  localparam logic [MODE_W-1:0] ACT_SIGMOID = MODE_W'(1);
  localparam logic [MODE_W-1:0] ACT_STEP    = MODE_W'(2);
  localparam logic [MODE_W-1:0] ACT_RELU    = MODE_W'(3);
  localparam logic [MODE_W-1:0] ACT_LEAKY   = MODE_W'(4);
  localparam logic [MODE_W-1:0] ACT_TANH    = MODE_W'(5);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = CFG_IDX_W'(2);

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(3);

  // sigmoid breakpoints and offsets, in units of one
  localparam logic [SIG_W-1:0] SIG_ONE  = SIG_W'(1 << FRAC_BITS);
  localparam logic [SIG_W-1:0] SIG_SAT  = SIG_W'(5 << FRAC_BITS);
  localparam logic [SIG_W-1:0] SIG_MID  = SIG_W'((19 << FRAC_BITS) >> 3);
  localparam logic [SIG_W-1:0] SIG_OFS5 = SIG_W'(27 << FRAC_BITS);
  localparam logic [SIG_W-1:0] SIG_OFS3 = SIG_W'(5 << FRAC_BITS);
  localparam logic [SIG_W-1:0] SIG_OFS2 = SIG_W'(2 << FRAC_BITS);

  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     sat;
  } result_t;

  // piecewise-linear sigmoid, result in 0..one
  function automatic logic [DATA_W-1:0] sigmoid_fx(input logic signed [MAG_W-1:0] x);
    logic [MAG_W-1:0] mag;
    logic [SIG_W-1:0] a;
    logic [SIG_W-1:0] y;
    logic [SIG_W-1:0] sum;
    mag = x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
    a   = SIG_W'(mag);
    if (a >= SIG_SAT) begin
      y = SIG_ONE;
    end else if (a >= SIG_MID) begin
      sum = a + SIG_OFS5;
      y   = sum >> 5;
    end else if (a >= SIG_ONE) begin
      sum = a + SIG_OFS3;
      y   = sum >> 3;
    end else begin
      sum = a + SIG_OFS2;
      y   = sum >> 2;
    end
    if (x[MAG_W-1]) begin
      y = SIG_ONE - y;
    end
    return DATA_W'(y);
  endfunction

endpackage

@@ rtl/neuron_dot_product_activation_unit.sv @@
// Single neuron: streaming multiply-accumulate followed by an activation.
// Input stream: one transaction per (value, weight) pair, in_tlast closes the
// dot product and its own product is included. Products are summed in a 40-bit
// saturating accumulator. On the last transaction the bias is added, the sum
// is rounded to Q8.8 and clipped, then identity, sigmoid, step, ReLU, leaky
// ReLU or tanh is applied per the mode register.
// Output stream: one transaction per closed dot product; tuser flags that the
// accumulator or the pre-activation was clipped.
// Throughput: one input transaction per cycle unless out_tready back-pressure
// stalls it, limited by the accumulator add loop. A result passes through the
// input reg, product, accumulate, bias, round/clip and activation registers.
// Each stage moves on when the next one is empty or moving, so input keeps
// flowing while a result waits on out_tready until every stage has filled.
// Reset (synchronous, rst_n low) empties the pipeline, clears the sum and
// loads mode 0, bias 0, slope 3. Configuration is written through cfg_wr_en;
// the user must do so while the stream is idle, the block does not enforce it.
module neuron_dot_product_activation_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ndpa_pkg::PROD_W-1:0] in_tdata,  // in_value[15:0], weight[31:16]
  input  logic                      in_tlast,     // is_last
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ndpa_pkg::DATA_W-1:0] out_tdata, // activation_out[15:0]
  output logic                      out_tuser,    // saturated
  input  logic                      cfg_wr_en,
  input  logic [ndpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ndpa_pkg::DATA_W-1:0] cfg_wdata
);
  import ndpa_pkg::*;

  localparam logic signed [ACC_W:0] SUM_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] SUM_MIN = {2'b11, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] OUT_MAX = (ACC_W+1)'((1 << (DATA_W-1)) - 1);
  localparam logic signed [ACC_W:0] OUT_MIN = -((ACC_W+1)'(1 << (DATA_W-1)));
  localparam logic signed [DATA_W+1:0] ONE_W = (DATA_W+2)'(1 << FRAC_BITS);

  // configuration
  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] bias_r;
  logic [SLOPE_W-1:0]       slope_r;

  // stage valids
  logic v_in_r, v_prod_r, v_fin_r, v_pre_r, v_x_r, out_valid_r;
  logic adv_in, adv_prod, adv_fin, adv_pre, adv_x;
  logic free_prod, free_fin, free_pre, free_x, free_out;

  // payload
  logic signed [DATA_W-1:0] val_r, wgt_r;
  logic                     last_in_r, last_prod_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  sum_r, sum_nxt;
  logic                     sum_clip_r, sum_clip_nxt;
  logic signed [ACC_W-1:0]  fin_sum_r;
  logic                     fin_clip_r;
  logic signed [ACC_W-1:0]  pre_sum_r;
  logic                     pre_clip_r;
  logic signed [DATA_W-1:0] x_r;
  logic                     x_clip_r;
  result_t                  out_r;

  // ready chain from the output register back
  assign free_out  = !out_valid_r || out_tready;
  assign adv_x     = v_x_r && free_out;
  assign free_x    = !v_x_r || adv_x;
  assign adv_pre   = v_pre_r && free_x;
  assign free_pre  = !v_pre_r || adv_pre;
  assign adv_fin   = v_fin_r && free_pre;
  assign free_fin  = !v_fin_r || adv_fin;
  // non-last items only touch the accumulator and need no downstream slot
  assign adv_prod  = v_prod_r && (!last_prod_r || free_fin);
  assign free_prod = !v_prod_r || adv_prod;
  assign adv_in    = v_in_r && free_prod;
  assign in_tready = !v_in_r || adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ACT_NONE;
      bias_r  <= '0;
      slope_r <= SLOPE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_BIAS:  bias_r  <= $signed(cfg_wdata);
        CFG_SLOPE: slope_r <= cfg_wdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulate with saturation
  logic signed [ACC_W:0] acc_sum;
  always_comb begin
    acc_sum = (ACC_W+1)'(sum_r) + (ACC_W+1)'(prod_r);
    sum_clip_nxt = sum_clip_r;
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      sum_nxt = acc_sum[ACC_W] ? SUM_MIN[ACC_W-1:0] : SUM_MAX[ACC_W-1:0];
      sum_clip_nxt = 1'b1;
    end else begin
      sum_nxt = acc_sum[ACC_W-1:0];
    end
  end

  // bias add with saturation
  logic signed [ACC_W:0] bias_ext, bias_sum;
  logic signed [ACC_W-1:0] pre_sum_nxt;
  logic                    pre_clip_nxt;
  always_comb begin
    bias_ext = (ACC_W+1)'(bias_r) <<< FRAC_BITS;
    bias_sum = (ACC_W+1)'(fin_sum_r) + bias_ext;
    pre_clip_nxt = fin_clip_r;
    if (bias_sum[ACC_W] != bias_sum[ACC_W-1]) begin
      pre_sum_nxt = bias_sum[ACC_W] ? SUM_MIN[ACC_W-1:0] : SUM_MAX[ACC_W-1:0];
      pre_clip_nxt = 1'b1;
    end else begin
      pre_sum_nxt = bias_sum[ACC_W-1:0];
    end
  end

  // round half up to output format, clip to 16 bits
  logic signed [ACC_W:0] rnd_t, rnd_q;
  logic signed [DATA_W-1:0] x_nxt;
  logic                     x_clip_nxt;
  always_comb begin
    rnd_t = (ACC_W+1)'(pre_sum_r) + RND_HALF;
    rnd_q = rnd_t >>> FRAC_BITS;
    x_clip_nxt = pre_clip_r;
    if (rnd_q > OUT_MAX) begin
      x_nxt = OUT_MAX[DATA_W-1:0];
      x_clip_nxt = 1'b1;
    end else if (rnd_q < OUT_MIN) begin
      x_nxt = OUT_MIN[DATA_W-1:0];
      x_clip_nxt = 1'b1;
    end else begin
      x_nxt = rnd_q[DATA_W-1:0];
    end
  end

  // activation
  logic signed [DATA_W+SLOPE_W:0] leaky_p;
  logic [DATA_W-1:0]              sig_y, tanh_s;
  logic signed [DATA_W+1:0]       tanh_t;
  result_t                        res_nxt;
  always_comb begin
    leaky_p = $signed(x_r) * $signed({1'b0, slope_r});
    sig_y   = sigmoid_fx(MAG_W'(x_r));
    tanh_s  = sigmoid_fx($signed({x_r, 1'b0}));
    tanh_t  = $signed({1'b0, tanh_s, 1'b0}) - ONE_W;
    res_nxt.sat = x_clip_r;
    case (mode_r)
      ACT_SIGMOID: res_nxt.data = $signed(sig_y);
      ACT_STEP:    res_nxt.data = x_r[DATA_W-1] ? '0 : ONE_Q;
      ACT_RELU:    res_nxt.data = x_r[DATA_W-1] ? '0 : x_r;
      ACT_LEAKY:   res_nxt.data = x_r[DATA_W-1] ? leaky_p[DATA_W+SLOPE_W-1:SLOPE_W] : x_r;
      ACT_TANH:    res_nxt.data = tanh_t[DATA_W-1:0];
      default:     res_nxt.data = x_r;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r      <= 1'b0;
      v_prod_r    <= 1'b0;
      v_fin_r     <= 1'b0;
      v_pre_r     <= 1'b0;
      v_x_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      sum_clip_r  <= 1'b0;
    end else begin
      if (in_tready) v_in_r <= in_tvalid;
      if (free_prod) v_prod_r <= adv_in;
      if (free_fin)  v_fin_r <= adv_prod && last_prod_r;
      if (free_pre)  v_pre_r <= adv_fin;
      if (free_x)    v_x_r <= adv_pre;
      if (free_out)  out_valid_r <= adv_x;
      if (adv_prod) begin
        if (last_prod_r) begin
          sum_r      <= '0;
          sum_clip_r <= 1'b0;
        end else begin
          sum_r      <= sum_nxt;
          sum_clip_r <= sum_clip_nxt;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      val_r     <= $signed(in_tdata[DATA_W-1:0]);
      wgt_r     <= $signed(in_tdata[PROD_W-1:DATA_W]);
      last_in_r <= in_tlast;
    end
    if (adv_in) begin
      prod_r      <= val_r * wgt_r;
      last_prod_r <= last_in_r;
    end
    if (adv_prod && last_prod_r) begin
      fin_sum_r  <= sum_nxt;
      fin_clip_r <= sum_clip_nxt;
    end
    if (adv_fin) begin
      pre_sum_r  <= pre_sum_nxt;
      pre_clip_r <= pre_clip_nxt;
    end
    if (adv_pre) begin
      x_r      <= x_nxt;
      x_clip_r <= x_clip_nxt;
    end
    if (adv_x) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.sat;

endmodule

@@ sim/tb_neuron_dot_product_activation_unit.sv @@
`timescale 1ns / 1ps

module tb_neuron_dot_product_activation_unit;
  import ndpa_pkg::*;

  // unused mode codes, both behave as identity
  localparam logic [MODE_W-1:0] ACT_SPARE6 = MODE_W'(6);
  localparam logic [MODE_W-1:0] ACT_SPARE7 = MODE_W'(7);

  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -(longint'(1) <<< (ACC_W - 1));
  localparam longint Q_MAX   = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint Q_MIN   = -(longint'(1) <<< (DATA_W - 1));
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  class neuron_scoreboard;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] bias;
    logic [SLOPE_W-1:0]       slope;
    longint                   acc;
    bit                       acc_clip;
    result_t                  expected_outputs[$];
    int                       fails;

    function new();
      mode     = ACT_NONE;
      bias     = '0;
      slope    = SLOPE_RESET;
      acc      = 0;
      acc_clip = 1'b0;
      fails    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      fails++;
    endtask

    function int pending();
      return expected_outputs.size();
    endfunction

    function longint clip40(longint v, inout bit flag);
      if (v > ACC_MAX) begin
        flag = 1'b1;
        return ACC_MAX;
      end
      if (v < ACC_MIN) begin
        flag = 1'b1;
        return ACC_MIN;
      end
      return v;
    endfunction

    // piecewise-linear curve on |x|, mirrored for negative x
    function int sigmoid_pwl(int x);
      int one;
      int a;
      int y;
      one = 1 << FRAC_BITS;
      a   = (x < 0) ? -x : x;
      if (a >= 5 * one) begin
        y = one;
      end else if (a >= ((19 * one) >> 3)) begin
        y = (a + 27 * one) >> 5;
      end else if (a >= one) begin
        y = (a + 5 * one) >> 3;
      end else begin
        y = (a + 2 * one) >> 2;
      end
      return (x < 0) ? one - y : y;
    endfunction

    function int activate(int x);
      int one;
      one = 1 << FRAC_BITS;
      case (mode)
        ACT_SIGMOID: begin
          return sigmoid_pwl(x);
        end
        ACT_STEP: begin
          return (x < 0) ? 0 : one;
        end
        ACT_RELU: begin
          return (x < 0) ? 0 : x;
        end
        ACT_LEAKY: begin
          if (x >= 0) return x;
          return int'((longint'(x) * longint'(slope)) >>> 8);
        end
        ACT_TANH: begin
          return 2 * sigmoid_pwl(2 * x) - one;
        end
        default: begin
          return x;
        end
      endcase
    endfunction

    function void accumulate_pair(logic signed [DATA_W-1:0] v, logic signed [DATA_W-1:0] w,
                                  logic last);
      longint  s;
      longint  r;
      bit      clip;
      result_t res;
      acc = clip40(acc + longint'(v) * longint'(w), acc_clip);
      if (!last) return;
      clip = acc_clip;
      s = clip40(acc + (longint'(bias) <<< FRAC_BITS), clip);
      // halves round toward +inf
      r = (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > Q_MAX) begin
        r    = Q_MAX;
        clip = 1'b1;
      end
      if (r < Q_MIN) begin
        r    = Q_MIN;
        clip = 1'b1;
      end
      res.data = DATA_W'(activate(int'(r)));
      res.sat  = clip;
      expected_outputs = {expected_outputs, res};
      acc      = 0;
      acc_clip = 1'b0;
    endfunction

    task check_activation(logic [DATA_W-1:0] data, logic sat);
      result_t want;
      if (expected_outputs.size() == 0) begin
        report($sformatf("result data=%h sat=%0b with nothing pending", data, sat));
        return;
      end
      want = expected_outputs.pop_front();
      if (data !== want.data) begin
        report($sformatf("activation_out got %h want %h (mode %0d)", data, want.data, mode));
      end
      if (sat !== want.sat) begin
        report($sformatf("saturated got %0b want %0b (data %h)", sat, want.sat, want.data));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [PROD_W-1:0]      in_tdata;   // in_value[15:0], weight[31:16]
  logic                   in_tlast;   // is_last
  logic                   out_tvalid;
  logic                   out_tready;
  logic [DATA_W-1:0]      out_tdata;  // activation_out[15:0]
  logic                   out_tuser;  // saturated
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]      cfg_wdata;

  bit in_idle_on;
  bit out_idle_on;
  bit hold_req;

  neuron_scoreboard sb;

  logic signed [DATA_W-1:0] corner_vals[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                                               16'sh0001};

  neuron_dot_product_activation_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // entered and left at a falling edge
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] w,
                           input logic last);
    while (in_idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, v};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accumulate_pair(v, w, last);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MODE:  sb.mode  = MODE_W'(value);
      CFG_BIAS:  sb.bias  = value;
      CFG_SLOPE: sb.slope = SLOPE_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] bias,
                            input logic [SLOPE_W-1:0] slope);
    write_reg(CFG_MODE, DATA_W'(mode));
    write_reg(CFG_BIAS, bias);
    write_reg(CFG_SLOPE, DATA_W'(slope));
  endtask

  // stop offering, let every pending result out, then let the pipe settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic pick_pair(output logic signed [DATA_W-1:0] v,
                           output logic signed [DATA_W-1:0] w);
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // lands x around the sigmoid breakpoints
      v = DATA_W'(int'($urandom_range(4095)) - 2048);
      w = DATA_W'(int'($urandom_range(511)) - 256);
    end else if (kind < 70) begin
      v = DATA_W'($urandom);
      w = DATA_W'(int'($urandom_range(511)) - 256);
    end else if (kind < 85) begin
      v = DATA_W'($urandom);
      w = DATA_W'($urandom);
    end else begin
      v = corner_vals[$urandom_range(4)];
      w = corner_vals[$urandom_range(4)];
    end
  endtask

  task automatic random_config();
    logic signed [DATA_W-1:0] bias;
    logic [SLOPE_W-1:0]       slope;
    int unsigned              kind;
    kind = $urandom_range(99);
    if (kind < 25)      bias = '0;
    else if (kind < 35) bias = 16'sh8000;
    else if (kind < 45) bias = 16'sh7fff;
    else if (kind < 75) bias = DATA_W'(int'($urandom_range(2047)) - 1024);
    else                bias = DATA_W'($urandom);
    kind = $urandom_range(9);
    if (kind == 0)      slope = '0;
    else if (kind == 1) slope = '1;
    else if (kind == 2) slope = SLOPE_RESET;
    else                slope = SLOPE_W'($urandom);
    set_config(MODE_W'($urandom_range(7)), bias, slope);
  endtask

  task automatic random_frames(input int n_items);
    int                       sent;
    int                       len;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] w;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
      for (int i = 0; i < len; i++) begin
        pick_pair(v, w);
        send_item(v, w, i == len - 1);
      end
      sent += len;
    end
  endtask

  // result side
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= !out_idle_on || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_activation(out_tdata, out_tuser);
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_MODE;
    cfg_wdata   = '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    hold_req    = 1'b0;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: identity, output clipping, rounding of halves
    send_item(16'sh7fff, 16'sh7fff, 1'b1);
    send_item(16'sh8000, 16'sh7fff, 1'b1);
    send_item(128, 1, 1'b1);
    send_item(-128, 1, 1'b1);
    send_item(768, ONE_Q, 1'b0);
    send_item(-256, 512, 1'b1);
    quiesce();

    // weight of one makes x equal to the value
    set_config(ACT_SIGMOID, 0, SLOPE_RESET);
    send_item(608, ONE_Q, 1'b1);
    send_item(-1280, ONE_Q, 1'b1);
    send_item(255, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_STEP, 0, SLOPE_RESET);
    send_item(0, ONE_Q, 1'b1);
    send_item(-1, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_RELU, 0, SLOPE_RESET);
    send_item(-1, ONE_Q, 1'b1);
    send_item(300, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_LEAKY, 0, 8'hff);
    send_item(16'sh8000, ONE_Q, 1'b1);
    quiesce();
    write_reg(CFG_SLOPE, '0);
    send_item(-5, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_TANH, 0, SLOPE_RESET);
    send_item(304, ONE_Q, 1'b1);
    send_item(16'sh8000, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_SPARE6, 16'sh7fff, SLOPE_RESET);
    send_item(200, ONE_Q, 1'b1);
    quiesce();
    set_config(ACT_SPARE7, 16'sh8000, SLOPE_RESET);
    send_item(-1, ONE_Q, 1'b1);
    quiesce();

    for (int ph = 0; ph < 10; ph++) begin
      in_idle_on  = (ph != 3);
      out_idle_on = (ph != 3);
      random_config();
      random_frames((ph == 3) ? 60 : 10);
      quiesce();

      if (ph == 4) begin
        // receiver stalls long enough that the input side backs up
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
          send_item(DATA_W'(int'($urandom_range(4095)) - 2048), ONE_Q, 1'b1);
        end
        quiesce();
      end

      if (ph == 6) begin
        // accumulator runs into its upper 40-bit bound and steps down from it,
        // then a clean frame
        set_config(ACT_NONE, 0, SLOPE_RESET);
        for (int i = 0; i < 514; i++) begin
          send_item(16'sh8000, 16'sh8000, 1'b0);
        end
        for (int i = 0; i < 3; i++) begin
          send_item(16'sh7fff, 16'sh8000, i == 2);
        end
        send_item(1, 1, 1'b1);
        quiesce();
      end
    end

    in_tvalid <= 1'b0;
    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
